>>> rtl/core/aegm_pkg.sv
// aegm_pkg: shared types and constants for the amplitude envelope geometry mapper
// no dependencies; used by the interfaces, the arithmetic units and the top level

package aegm_pkg;

  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned RAYS_W   = 8;
  localparam int unsigned COUNT_W  = 64;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;

  // 1.0 in q1.16
  localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = 16'd65535;
  localparam logic [RAYS_W-1:0]   RAYS_LIMIT   = 8'd128;

  // restoring divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAYS_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAYS_MAX  = 3'd5;

  typedef struct packed {
    logic                accepted;
    logic [LEVEL_W-1:0]  raw_level;
    logic [LEVEL_W-1:0]  smoothed_level;
    logic [LEVEL_W-1:0]  level;
    logic [RADIUS_W-1:0] radius;
    logic [RAYS_W-1:0]   rays;
    logic                active;
    logic [COUNT_W-1:0]  accepted_count;
    logic [COUNT_W-1:0]  rejected_count;
  } out_beat_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/aegm_if.sv
// aegm_if: valid/ready channel interfaces for sample beats and result beats
// depends on aegm_pkg

interface aegm_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] amplitude;
  logic        not_finite;

  modport source (output valid, output amplitude, output not_finite, input ready);
  modport sink   (input valid, input amplitude, input not_finite, output ready);
endinterface

interface aegm_out_if;
  import aegm_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [LEVEL_W-1:0]  raw_level;
  logic [LEVEL_W-1:0]  smoothed_level;
  logic [LEVEL_W-1:0]  level;
  logic [RADIUS_W-1:0] radius;
  logic [RAYS_W-1:0]   rays;
  logic                active;
  logic [COUNT_W-1:0]  accepted_count;
  logic [COUNT_W-1:0]  rejected_count;

  modport source (output valid, output accepted, output raw_level, output smoothed_level,
                  output level, output radius, output rays, output active,
                  output accepted_count, output rejected_count, input ready);
  modport sink   (input valid, input accepted, input raw_level, input smoothed_level,
                  input level, input radius, input rays, input active,
                  input accepted_count, input rejected_count, output ready);
endinterface

>>> rtl/core/amplitude_envelope_geometry_mapper_top.sv
// amplitude_envelope_geometry_mapper_top: moving average with dead zone and geometry map
// depends on aegm_pkg, aegm_if, aegm_mul, aegm_div
//
//   channel  dir  width        payload
//   in_ch    in   33           amplitude (s q15.16), not_finite
//   out_ch   out  1+3*17+16+8+1+2*64  accepted, levels, radius, rays, active, counts
//   cfg_*    in   3 idx + 17   six registers, write only
//
// a rejected sample goes from idle straight to the done state, then to the result register
// an accepted sample runs the blend, level, divide, radius and ray states; the 17-step
// restoring divider computes the normalized level; below the dead zone it is skipped
// one shared 18x17 multiplier does the blend, radius and ray products in turn
// in_ch.ready is high only in the idle state; a finished beat waits in the output
// register, so the next sample is taken while out_ch is stalled
// rst_n is synchronous; counters, held values and registers return to reset values

module amplitude_envelope_geometry_mapper_top (
  input  logic                            clk,
  input  logic                            rst_n,
  aegm_in_if.sink                         in_ch,
  aegm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [aegm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [aegm_pkg::CFG_W-1:0]      cfg_data
);
  import aegm_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_MUL_BLEND = 9'b000000010,
    ST_BLEND     = 9'b000000100,
    ST_LVL       = 9'b000001000,
    ST_DIV       = 9'b000010000,
    ST_MUL_RAD   = 9'b000100000,
    ST_MUL_RAY   = 9'b001000000,
    ST_RAY_CAP   = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  // configuration registers
  logic [GAIN_W-1:0]   gain_r;
  logic [15:0]         dz_r;
  logic [RADIUS_W-1:0] rmin_r;
  logic [RADIUS_W-1:0] rmax_r;
  logic [RAYS_W-1:0]   ymin_r;
  logic [RAYS_W-1:0]   ymax_r;

  // held state
  logic [LEVEL_W-1:0]  raw_r;
  logic [LEVEL_W-1:0]  avg_r;
  logic [LEVEL_W-1:0]  last_raw_r;
  logic [LEVEL_W-1:0]  lvl_r;
  logic [RADIUS_W-1:0] rad_r;
  logic [RAYS_W-1:0]   rays_r;
  logic                act_r;
  logic [COUNT_W-1:0]  good_r;
  logic [COUNT_W-1:0]  bad_r;
  logic                acc_r;

  // result register
  out_beat_t out_r;
  logic      out_valid_r;

  logic in_beat;
  logic cfg_ok;
  logic reject;
  logic [LEVEL_W-1:0] raw_clamped;

  // shared multiplier
  logic               mul_en;
  logic signed [17:0] mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic signed [35:0] mul_prod;

  // divider
  logic               div_start;
  div_stat_t          div_stat;
  logic [LEVEL_W-1:0] div_quot;
  logic [LEVEL_W-1:0] div_num;
  logic [LEVEL_W-1:0] div_den;

  // blend datapath
  logic [17:0]        blend_diff;
  logic signed [35:0] blend_bias;
  logic signed [19:0] blend_step;
  logic signed [20:0] blend_sum;
  logic [LEVEL_W-1:0] blend_avg;

  logic [RADIUS_W-1:0] span_rad;
  logic [RAYS_W-1:0]   span_ray;
  logic [32:0]         round_prod;
  logic                above_dz;
  logic                out_free;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  assign cfg_ok = (gain_r != '0) && (gain_r <= ONE_Q16)
               && (rmax_r >= rmin_r) && (rmax_r <= RADIUS_LIMIT)
               && (ymax_r >= ymin_r) && (ymax_r <= RAYS_LIMIT);

  assign reject = !cfg_ok || in_ch.not_finite || in_ch.amplitude[31] || (&good_r);

  // clamp to 1.0; sign already excluded
  assign raw_clamped = ($unsigned(in_ch.amplitude) > {15'b0, ONE_Q16}) ? ONE_Q16
                     : in_ch.amplitude[LEVEL_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_W'(16384);
      dz_r   <= '0;
      rmin_r <= '0;
      rmax_r <= '0;
      ymin_r <= '0;
      ymax_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN:       gain_r <= cfg_data;
        REG_DEAD_ZONE:  dz_r   <= cfg_data[15:0];
        REG_RADIUS_MIN: rmin_r <= cfg_data[RADIUS_W-1:0];
        REG_RADIUS_MAX: rmax_r <= cfg_data[RADIUS_W-1:0];
        REG_RAYS_MIN:   ymin_r <= cfg_data[RAYS_W-1:0];
        REG_RAYS_MAX:   ymax_r <= cfg_data[RAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // blend: avg + round(gain * (raw - avg) / 2^16), halves toward +inf
  assign blend_diff = {1'b0, raw_r} - {1'b0, avg_r};
  assign blend_bias = mul_prod + 36'sd32768;
  assign blend_step = blend_bias[35:16];
  assign blend_sum  = $signed({4'b0000, avg_r}) + $signed({blend_step[19], blend_step});

  always_comb begin
    if (blend_sum[20]) begin
      blend_avg = '0;
    end else if (blend_sum > $signed({4'b0000, ONE_Q16})) begin
      blend_avg = ONE_Q16;
    end else begin
      blend_avg = blend_sum[LEVEL_W-1:0];
    end
  end

  assign span_rad   = rmax_r - rmin_r;
  assign span_ray   = ymax_r - ymin_r;
  assign round_prod = mul_prod[32:0] + 33'd32768;

  assign above_dz  = avg_r > {1'b0, dz_r};
  assign div_num   = avg_r - {1'b0, dz_r};
  assign div_den   = ONE_Q16 - {1'b0, dz_r};
  assign div_start = (st_r == ST_LVL) && above_dz;

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = {1'b0, lvl_r};
    mul_b  = gain_r;
    priority if (st_r == ST_MUL_BLEND) begin
      mul_en = 1'b1;
      mul_a  = blend_diff;
      mul_b  = gain_r;
    end else if (st_r == ST_MUL_RAD) begin
      mul_en = 1'b1;
      mul_b  = {1'b0, span_rad};
    end else if (st_r == ST_MUL_RAY) begin
      mul_en = 1'b1;
      mul_b  = {{(GAIN_W-RAYS_W){1'b0}}, span_ray};
    end else begin
      mul_en = 1'b0;
    end
  end

  aegm_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  aegm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:      if (in_beat) st_nxt = reject ? ST_DONE : ST_MUL_BLEND;
      ST_MUL_BLEND: st_nxt = ST_BLEND;
      ST_BLEND:     st_nxt = ST_LVL;
      ST_LVL:       st_nxt = above_dz ? ST_DIV : ST_MUL_RAD;
      ST_DIV:       if (div_stat.done) st_nxt = ST_MUL_RAD;
      ST_MUL_RAD:   st_nxt = ST_MUL_RAY;
      ST_MUL_RAY:   st_nxt = ST_RAY_CAP;
      ST_RAY_CAP:   st_nxt = ST_DONE;
      ST_DONE:      if (out_free) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // held state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r      <= '0;
      last_raw_r <= '0;
      lvl_r      <= '0;
      rad_r      <= '0;
      rays_r     <= '0;
      act_r      <= '0;
      good_r     <= '0;
      bad_r      <= '0;
      acc_r      <= 1'b0;
    end else begin
      if (in_beat) begin
        acc_r <= !reject;
        if (reject && !(&bad_r)) begin
          bad_r <= bad_r + 1'b1;
        end
      end
      if (st_r == ST_BLEND) begin
        avg_r      <= blend_avg;
        last_raw_r <= raw_r;
        good_r     <= good_r + 1'b1;
      end
      if (st_r == ST_LVL && !above_dz) begin
        lvl_r <= '0;
      end
      if (st_r == ST_DIV && div_stat.done) begin
        lvl_r <= div_quot;
      end
      if (st_r == ST_MUL_RAD) begin
        act_r <= (lvl_r != '0);
      end
      if (st_r == ST_MUL_RAY) begin
        rad_r <= rmin_r + round_prod[31:16];
      end
      if (st_r == ST_RAY_CAP) begin
        rays_r <= ymin_r + round_prod[23:16];
      end
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      raw_r <= raw_clamped;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && out_free) begin
      out_r.accepted       <= acc_r;
      out_r.raw_level      <= last_raw_r;
      out_r.smoothed_level <= avg_r;
      out_r.level          <= lvl_r;
      out_r.radius         <= rad_r;
      out_r.rays           <= rays_r;
      out_r.active         <= act_r;
      out_r.accepted_count <= good_r;
      out_r.rejected_count <= bad_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_r.accepted;
  assign out_ch.raw_level      = out_r.raw_level;
  assign out_ch.smoothed_level = out_r.smoothed_level;
  assign out_ch.level          = out_r.level;
  assign out_ch.radius         = out_r.radius;
  assign out_ch.rays           = out_r.rays;
  assign out_ch.active         = out_r.active;
  assign out_ch.accepted_count = out_r.accepted_count;
  assign out_ch.rejected_count = out_r.rejected_count;

  // the divider never runs while a new sample can be taken
  a_ready_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (st_r == ST_DIV))
    else $error("divider done outside divide state");

  // accepted count moves by exactly one per accepted sample
  a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BLEND) |=> (good_r == $past(good_r) + 1'b1))
    else $error("accepted count step wrong");

  // the average stays within q1.16 range
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_r.smoothed_level <= ONE_Q16))
    else $error("average above one");

endmodule

>>> rtl/core/aegm_mul.sv
// aegm_mul: shared registered multiplier, signed 18 bit by unsigned 17 bit
// depends on aegm_pkg

module aegm_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [17:0]           a,
  input  logic [aegm_pkg::GAIN_W-1:0]  b,
  output logic signed [35:0]           prod
);
  import aegm_pkg::*;

  logic signed [35:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * $signed({1'b0, b});
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/aegm_div.sv
// aegm_div: restoring divider, rounded quotient of (num * 2^16) / den
// depends on aegm_pkg; quotient must fit in 17 bits (num <= den)

module aegm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aegm_pkg::LEVEL_W-1:0]  num,
  input  logic [aegm_pkg::LEVEL_W-1:0]  den,
  output aegm_pkg::div_stat_t           stat,
  output logic [aegm_pkg::LEVEL_W-1:0]  quot
);
  import aegm_pkg::*;

  logic [LEVEL_W-1:0]   rem_r;
  logic [LEVEL_W-1:0]   lo_r;
  logic [LEVEL_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [2*LEVEL_W-1:0] dividend;
  logic [LEVEL_W:0]     trial;
  logic [LEVEL_W:0]     trial_sub;
  logic                 trial_ge;

  // add half the divisor for round-half-up
  assign dividend  = {num, 16'b0} + {{(LEVEL_W+1){1'b0}}, den[LEVEL_W-1:1]};
  assign trial     = {rem_r, lo_r[LEVEL_W-1]};
  assign trial_ge  = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*LEVEL_W-1:LEVEL_W];
      lo_r  <= dividend[LEVEL_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= trial_ge ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
      lo_r  <= {lo_r[LEVEL_W-2:0], trial_ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = lo_r;

endmodule

>>> tb/tb_amplitude_envelope_geometry_mapper_top.sv
// self-checking testbench for the amplitude envelope geometry mapper
// drives sample beats and register writes, predicts every result beat and compares
// depends on aegm_pkg, aegm_if and the rtl top level
`timescale 1ns / 100ps

module tb_amplitude_envelope_geometry_mapper_top;
  import aegm_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int IDLE_PCT        = 29;
  localparam int HOLDOFF_CYCLES  = 250;
  localparam int QUIET_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 40;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int MAX_REPORTS     = 10;

  // phases of the random part with a special job
  localparam int CALM_PHASE  = 3;
  localparam int HOLD_PHASE  = 7;
  localparam int PAUSE_PHASE = 9;

  // register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [GAIN_W-1:0]   gain;
    logic [15:0]         dead_zone;
    logic [RADIUS_W-1:0] radius_min;
    logic [RADIUS_W-1:0] radius_max;
    logic [RAYS_W-1:0]   rays_min;
    logic [RAYS_W-1:0]   rays_max;
  } reg_file_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // one line of the directed table: a register write or a sample beat,
  // optionally with its result typed in by hand
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_W-1:0]     data;
    logic [31:0]          amp;
    logic                 not_finite;
    bit                   typed;
    out_beat_t            want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_data;

  aegm_in_if  in_ch ();
  aegm_out_if out_ch ();

  amplitude_envelope_geometry_mapper_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of the registers and the held state
  reg_file_t          regs;
  logic [LEVEL_W-1:0] avg_q;
  logic [LEVEL_W-1:0] raw_q;
  logic [LEVEL_W-1:0] level_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [RAYS_W-1:0]  rays_q;
  logic               active_q;
  logic [COUNT_W-1:0] good_q;
  logic [COUNT_W-1:0] bad_q;

  // result beats still owed by the block, oldest first
  out_beat_t expected_beats[$];
  plan_row_t plan[$];

  int mismatches    = 0;
  int beats_checked = 0;
  int samples_sent  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  // idling controls shared between the sender and the receiver
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;
  int holdoff_req  = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  // register write as the block sees it: masked to width, unknown index dropped
  function automatic void apply_write(logic [CFG_IDX_W-1:0] addr, logic [CFG_W-1:0] data);
    case (addr)
      REG_GAIN:       regs.gain       = data[GAIN_W-1:0];
      REG_DEAD_ZONE:  regs.dead_zone  = data[15:0];
      REG_RADIUS_MIN: regs.radius_min = data[RADIUS_W-1:0];
      REG_RADIUS_MAX: regs.radius_max = data[RADIUS_W-1:0];
      REG_RAYS_MIN:   regs.rays_min   = data[RAYS_W-1:0];
      REG_RAYS_MAX:   regs.rays_max   = data[RAYS_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample through the envelope: reject or blend, then map to geometry
  function automatic out_beat_t predict_envelope(logic [31:0] amp, logic not_finite);
    out_beat_t beat;
    logic [LEVEL_W-1:0] raw;
    longint diff;
    longint prod;
    longint step;
    longint blended;
    longint unsigned num;
    longint unsigned den;
    longint unsigned lvl;
    longint unsigned span;
    int rays_calc;
    bit config_ok;
    config_ok = regs.gain != 0 && regs.gain <= ONE_Q16
             && regs.radius_max >= regs.radius_min && regs.radius_max <= RADIUS_LIMIT
             && regs.rays_max >= regs.rays_min && regs.rays_max <= RAYS_LIMIT;
    if (!config_ok || not_finite || amp[31] || good_q == '1) begin
      // rejected beat: counts only, held values stay
      if (bad_q != '1) bad_q++;
      beat.accepted = 1'b0;
    end else begin
      raw = (amp > ONE_Q16) ? ONE_Q16 : amp[LEVEL_W-1:0];
      // blend with halves rounding toward plus infinity
      diff = longint'(raw) - longint'(avg_q);
      prod = longint'(regs.gain) * diff;
      step = (prod + 32768) >>> 16;
      blended = longint'(avg_q) + step;
      if (blended < 0) blended = 0;
      if (blended > 65536) blended = 65536;
      avg_q = blended[LEVEL_W-1:0];
      raw_q = raw;
      // rescale above the dead zone
      lvl = 0;
      if (avg_q > regs.dead_zone) begin
        num = longint'(avg_q - regs.dead_zone) << 16;
        den = 65536 - regs.dead_zone;
        lvl = (num + den / 2) / den;
        if (lvl > 65536) lvl = 65536;
      end
      level_q = lvl[LEVEL_W-1:0];
      span = regs.radius_max - regs.radius_min;
      radius_q = regs.radius_min + RADIUS_W'((lvl * span + 32768) >> 16);
      span = regs.rays_max - regs.rays_min;
      rays_calc = int'(regs.rays_min) + int'((lvl * span + 32768) >> 16);
      if (rays_calc < regs.rays_min) rays_calc = regs.rays_min;
      if (rays_calc > regs.rays_max) rays_calc = regs.rays_max;
      rays_q = rays_calc[RAYS_W-1:0];
      active_q = lvl != 0;
      good_q++;
      beat.accepted = 1'b1;
    end
    beat.raw_level      = raw_q;
    beat.smoothed_level = avg_q;
    beat.level          = level_q;
    beat.radius         = radius_q;
    beat.rays           = rays_q;
    beat.active         = active_q;
    beat.accepted_count = good_q;
    beat.rejected_count = bad_q;
    return beat;
  endfunction

  function automatic out_beat_t mk_beat(logic acc, logic [LEVEL_W-1:0] raw,
                                        logic [LEVEL_W-1:0] smoothed,
                                        logic [LEVEL_W-1:0] lvl,
                                        logic [RADIUS_W-1:0] radius,
                                        logic [RAYS_W-1:0] rays, logic act,
                                        logic [COUNT_W-1:0] good,
                                        logic [COUNT_W-1:0] bad);
    out_beat_t beat;
    beat.accepted       = acc;
    beat.raw_level      = raw;
    beat.smoothed_level = smoothed;
    beat.level          = lvl;
    beat.radius         = radius;
    beat.rays           = rays;
    beat.active         = act;
    beat.accepted_count = good;
    beat.rejected_count = bad;
    return beat;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] addr, logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, addr: addr, data: data, amp: '0, not_finite: 1'b0,
            typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t sample_row(logic [31:0] amp, logic not_finite,
                                           bit typed = 1'b0, out_beat_t want = '0);
    plan_row_t row;
    row = '{kind: ROW_SAMPLE, addr: '0, data: '0, amp: amp, not_finite: not_finite,
            typed: typed, want: want};
    return row;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // compare one result beat against the oldest expectation
  task automatic check_result_beat();
    out_beat_t want;
    beats_checked++;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: result beat with nothing expected", $time);
    end else begin
      want = expected_beats.pop_front();
      compare_field("accepted", want.accepted, out_ch.accepted);
      compare_field("raw_level", want.raw_level, out_ch.raw_level);
      compare_field("smoothed_level", want.smoothed_level, out_ch.smoothed_level);
      compare_field("level", want.level, out_ch.level);
      compare_field("radius", want.radius, out_ch.radius);
      compare_field("rays", want.rays, out_ch.rays);
      compare_field("active", want.active, out_ch.active);
      compare_field("accepted_count", want.accepted_count, out_ch.accepted_count);
      compare_field("rejected_count", want.rejected_count, out_ch.rejected_count);
    end
  endtask

  // register write; the enable stays up for back-to-back writes and is
  // dropped by the next sample
  task automatic program_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    apply_write(addr, data);
    @(posedge clk);
  endtask

  // stop offering and wait until every owed result beat has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // offer one sample beat, hold it until taken, then queue its result
  task automatic send_sample(input logic [31:0] amp, input logic not_finite,
                             input bit typed = 1'b0, input out_beat_t want = '0);
    out_beat_t predicted;
    cfg_we <= 1'b0;
    while (!src_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.amplitude  <= amp;
    in_ch.not_finite <= not_finite;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_envelope(amp, not_finite);
    // hand-typed rows still run the predictor so its state keeps up
    expected_beats.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // receiver: checks taken beats, then decides ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result_beat();
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else if (holdoff_seen != holdoff_req) begin
      // long back-pressure so the block fills up and stalls its input
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= sink_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reg_file_t  s;
    logic [31:0] amp;
    logic        not_finite;
    int          pick;
    bit          prev_write;

    // everything known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.amplitude  = '0;
    in_ch.not_finite = 1'b0;
    out_ch.ready     = 1'b0;

    // predictor reset values
    regs = '{gain: 17'd16384, dead_zone: '0, radius_min: '0, radius_max: '0,
             rays_min: '0, rays_max: '0};
    avg_q = '0;
    raw_q = '0;
    level_q = '0;
    radius_q = '0;
    rays_q = '0;
    active_q = 1'b0;
    good_q = '0;
    bad_q = '0;

    // directed table
    // straight after reset: rejects show zeroed held values, not the minimums
    plan.push_back(sample_row(32'h8000_0000, 1'b0, 1'b1,
                              mk_beat(1'b0, 0, 0, 0, 0, 0, 1'b0, 0, 1)));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b1, 1'b1,
                              mk_beat(1'b0, 0, 0, 0, 0, 0, 1'b0, 0, 2)));
    plan.push_back(sample_row(32'hFFFF_FFFF, 1'b0, 1'b1,
                              mk_beat(1'b0, 0, 0, 0, 0, 0, 1'b0, 0, 3)));
    plan.push_back(sample_row(32'h0000_0000, 1'b0, 1'b1,
                              mk_beat(1'b1, 0, 0, 0, 0, 0, 1'b0, 1, 3)));
    // largest positive clamps to 1.0, quarter-gain step lands on 0.25
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, 1'b1,
                              mk_beat(1'b1, ONE_Q16, 16384, 16384, 0, 0, 1'b1, 2, 3)));
    // widest spans; writes to unmapped indexes must change nothing
    plan.push_back(write_row(REG_RADIUS_MAX, 17'h0FFFF));
    plan.push_back(write_row(REG_RAYS_MAX, 17'd128));
    plan.push_back(write_row(REG_UNMAPPED_LO, 17'h1FFFF));
    plan.push_back(write_row(REG_UNMAPPED_HI, 17'h1FFFF));
    plan.push_back(sample_row(32'h0001_0000, 1'b0));
    plan.push_back(sample_row(32'h0001_0001, 1'b0));
    plan.push_back(sample_row(32'h0000_0001, 1'b0));
    plan.push_back(sample_row(32'h0000_8000, 1'b1));
    // full gain follows the sample exactly; top dead zone leaves only 1.0 alive
    plan.push_back(write_row(REG_GAIN, ONE_Q16));
    plan.push_back(write_row(REG_DEAD_ZONE, 17'h0FFFF));
    plan.push_back(sample_row(32'h0001_0000, 1'b0, 1'b1,
                              mk_beat(1'b1, ONE_Q16, ONE_Q16, ONE_Q16, 16'hFFFF, 8'd128,
                                      1'b1, 6, 4)));
    plan.push_back(sample_row(32'h0000_FFFF, 1'b0, 1'b1,
                              mk_beat(1'b1, 17'hFFFF, 17'hFFFF, 0, 0, 0, 1'b0, 7, 4)));
    // mid dead zone with nonzero minimums
    plan.push_back(write_row(REG_DEAD_ZONE, 17'd32768));
    plan.push_back(write_row(REG_RADIUS_MIN, 17'd100));
    plan.push_back(write_row(REG_RAYS_MIN, 17'd5));
    plan.push_back(sample_row(32'd40000, 1'b0));
    plan.push_back(sample_row(32'hFFFF_0000, 1'b1));
    // each way of making the setup invalid rejects the sample
    plan.push_back(write_row(REG_GAIN, 17'd0));
    plan.push_back(sample_row(32'd1000, 1'b0));
    plan.push_back(write_row(REG_GAIN, 17'h1FFFF));
    plan.push_back(sample_row(32'd70000, 1'b0));
    plan.push_back(write_row(REG_GAIN, 17'd1));
    plan.push_back(write_row(REG_RADIUS_MAX, 17'd50));
    plan.push_back(sample_row(32'd2000, 1'b0));
    plan.push_back(write_row(REG_RADIUS_MAX, 17'h0FFFF));
    plan.push_back(write_row(REG_RAYS_MAX, 17'd200));
    plan.push_back(sample_row(32'd3000, 1'b0));
    plan.push_back(write_row(REG_RAYS_MAX, 17'd4));
    plan.push_back(sample_row(32'd3000, 1'b0));
    // back to valid with the smallest gain
    plan.push_back(write_row(REG_RAYS_MIN, 17'd0));
    plan.push_back(write_row(REG_RAYS_MAX, 17'd128));
    plan.push_back(sample_row(32'h0001_0000, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    prev_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        // registers only change while the block is idle
        if (!prev_write) begin
          drain_results();
          settings_used++;
        end
        program_reg(plan[i].addr, plan[i].data);
        prev_write = 1'b1;
      end else begin
        send_sample(plan[i].amp, plan[i].not_finite, plan[i].typed, plan[i].want);
        prev_write = 1'b0;
      end
    end

    // random phases, each under a fresh register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          s.gain = ONE_Q16;
          s.dead_zone = '0;
          s.radius_min = '0;
          s.radius_max = 16'hFFFF;
          s.rays_min = '0;
          s.rays_max = RAYS_LIMIT;
        end
        1: begin
          s.gain = 17'd1;
          s.dead_zone = 16'hFFFF;
          s.radius_min = 16'hFFFF;
          s.radius_max = 16'hFFFF;
          s.rays_min = RAYS_LIMIT;
          s.rays_max = RAYS_LIMIT;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: s.gain = 17'd1;
            1: s.gain = ONE_Q16;
            default: s.gain = $urandom_range(1, 65536);
          endcase
          case ($urandom_range(0, 3))
            0: s.dead_zone = '0;
            1: s.dead_zone = 16'hFFFF - $urandom_range(0, 255);
            2: s.dead_zone = $urandom_range(0, 4095);
            default: s.dead_zone = $urandom_range(0, 65535);
          endcase
          s.radius_min = $urandom_range(0, 65535);
          s.radius_max = $urandom_range(s.radius_min, 65535);
          s.rays_min = $urandom_range(0, 128);
          s.rays_max = $urandom_range(s.rays_min, 128);
        end
      endcase
      // two phases run with a broken setup, everything rejected
      if (p == 5 || p == 10) begin
        case ($urandom_range(0, 4))
          0: s.gain = '0;
          1: s.gain = $urandom_range(65537, 131071);
          2: begin
            if (s.radius_min == 0) s.radius_min = 16'd1;
            s.radius_max = $urandom_range(0, s.radius_min - 1);
          end
          3: begin
            if (s.rays_min == 0) s.rays_min = 8'd1;
            s.rays_max = $urandom_range(0, s.rays_min - 1);
          end
          default: s.rays_max = $urandom_range(129, 255);
        endcase
      end
      program_reg(REG_GAIN, s.gain);
      program_reg(REG_DEAD_ZONE, s.dead_zone);
      program_reg(REG_RADIUS_MIN, s.radius_min);
      program_reg(REG_RADIUS_MAX, s.radius_max);
      program_reg(REG_RAYS_MIN, s.rays_min);
      program_reg(REG_RAYS_MAX, s.rays_max);
      settings_used++;

      // one phase with no idling on either side
      src_calm  = (p == CALM_PHASE);
      sink_calm = (p == CALM_PHASE);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == HOLD_PHASE && n == 4) holdoff_req++;
        if (p == PAUSE_PHASE && n == 15) drain_results();
        pick = $urandom_range(0, 99);
        not_finite = 1'b0;
        // mostly in-range samples, the rest clamped, negative or flagged
        if (pick < 60) amp = $urandom_range(0, 67000);
        else if (pick < 68) amp = pick[0] ? 32'(ONE_Q16) : 32'd0;
        else if (pick < 78) amp = {1'b0, 31'($urandom)};
        else if (pick < 88) amp = {1'b1, 31'($urandom)};
        else begin
          amp = $urandom;
          not_finite = 1'b1;
        end
        send_sample(amp, not_finite);
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    // let the last beats come back, then watch for stray ones
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d result beats checked, %0d register settings",
             samples_sent, beats_checked, settings_used);
    $display("predicted %0d accepted and %0d rejected samples, %0d mismatches",
             good_q, bad_q, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/aegm_pkg.sv
rtl/core/aegm_if.sv
rtl/core/aegm_mul.sv
rtl/core/aegm_div.sv
rtl/core/amplitude_envelope_geometry_mapper_top.sv
tb/tb_amplitude_envelope_geometry_mapper_top.sv
